FILE: rtl/rrtp_pkg.sv
package rrtp_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W     = 3;
    localparam int CNT_W      = 4;
    localparam int CMD_W      = 3;
    localparam int QIDX_W     = 4;

    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FINISH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic scan;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_rot;
        logic hit;
    } t_dp_sts;

endpackage

FILE: rtl/rrtp_ctrl.sv
module rrtp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  rrtp_pkg::t_dp_sts i_sts,
    output rrtp_pkg::t_dp_cmd o_cmd
);

    rrtp_pkg::t_state r_state, n_state;
    logic             r_valid, n_valid;
    logic             out_free;

    assign out_free = !r_valid || i_ready;
    assign o_ready  = (r_state == rrtp_pkg::ST_IDLE);
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrtp_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_ready;
        o_cmd   = '0;
        case (r_state)
            rrtp_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = rrtp_pkg::ST_EXEC;
                end
            end
            rrtp_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_rot ? rrtp_pkg::ST_SCAN : rrtp_pkg::ST_OUT;
            end
            rrtp_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = rrtp_pkg::ST_OUT;
                end
            end
            rrtp_pkg::ST_OUT: begin
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_valid    = 1'b1;
                    n_state    = rrtp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rrtp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/rrtp_dp.sv
module rrtp_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rrtp_pkg::t_dp_cmd            i_cmd_ctl,
    output rrtp_pkg::t_dp_sts            o_sts,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic [rrtp_pkg::CMD_W-1:0]   i_cmd,
    input  logic                         i_process_active,
    input  logic [rrtp_pkg::QIDX_W-1:0]  i_task_index,
    output logic                         o_status,
    output logic [rrtp_pkg::SLOT_W-1:0]  o_assigned_slot,
    output logic                         o_running_is_main,
    output logic [rrtp_pkg::SLOT_W-1:0]  o_running_task,
    output logic [rrtp_pkg::CNT_W-1:0]   o_task_total,
    output logic                         o_queried_done
);

    logic                          r_preempt;
    logic [rrtp_pkg::CNT_W-1:0]    r_count;
    logic                          r_main;
    logic [rrtp_pkg::SLOT_W-1:0]   r_cur;
    logic [rrtp_pkg::TASK_SLOTS-1:0] r_done;

    logic [rrtp_pkg::CMD_W-1:0]    r_cmd;
    logic                          r_pact;
    logic [rrtp_pkg::QIDX_W-1:0]   r_qidx;
    logic [rrtp_pkg::CNT_W-1:0]    r_idx;

    logic                          r_res_status;
    logic [rrtp_pkg::SLOT_W-1:0]   r_res_assigned;
    logic                          r_res_qdone;

    logic                          r_o_status;
    logic [rrtp_pkg::SLOT_W-1:0]   r_o_assigned;
    logic                          r_o_main;
    logic [rrtp_pkg::SLOT_W-1:0]   r_o_task;
    logic [rrtp_pkg::CNT_W-1:0]    r_o_total;
    logic                          r_o_qdone;

    logic                          full;
    logic                          scan_main;

    assign full      = (r_count >= rrtp_pkg::CNT_W'(rrtp_pkg::TASK_SLOTS));
    assign scan_main = (r_idx == r_count);

    assign o_sts.need_rot = (r_count != '0) &&
                            ((r_cmd == rrtp_pkg::CMD_YIELD) ||
                             ((r_cmd == rrtp_pkg::CMD_TICK) && r_preempt && !r_pact) ||
                             ((r_cmd == rrtp_pkg::CMD_FINISH) && !r_main));
    assign o_sts.hit = scan_main || !r_done[r_idx[rrtp_pkg::SLOT_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preempt <= 1'b0;
            r_count   <= '0;
            r_main    <= 1'b1;
            r_cur     <= '0;
            r_done    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_preempt <= i_cfg_wdata;
            end
            if (i_cmd_ctl.exec) begin
                case (r_cmd)
                    rrtp_pkg::CMD_CREATE: begin
                        if (!full) begin
                            r_done[r_count[rrtp_pkg::SLOT_W-1:0]] <= 1'b0;
                            r_count <= r_count + 1'b1;
                        end
                    end
                    rrtp_pkg::CMD_FINISH: begin
                        if (!r_main) begin
                            r_done[r_cur] <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd_ctl.scan && o_sts.hit) begin
                if (scan_main) begin
                    r_main <= 1'b1;
                    r_cur  <= '0;
                end else begin
                    r_main <= 1'b0;
                    r_cur  <= r_idx[rrtp_pkg::SLOT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.accept) begin
            r_cmd  <= i_cmd;
            r_pact <= i_process_active;
            r_qidx <= i_task_index;
        end
        if (i_cmd_ctl.exec) begin
            r_res_status   <= 1'b0;
            r_res_assigned <= '0;
            r_res_qdone    <= 1'b0;
            r_idx          <= r_main ? '0 : ({1'b0, r_cur} + 1'b1);
            case (r_cmd)
                rrtp_pkg::CMD_CREATE: begin
                    if (full) begin
                        r_res_status <= 1'b1;
                    end else begin
                        r_res_assigned <= r_count[rrtp_pkg::SLOT_W-1:0];
                    end
                end
                rrtp_pkg::CMD_QUERY: begin
                    if ((r_qidx >= r_count) ||
                        (r_qidx >= rrtp_pkg::QIDX_W'(rrtp_pkg::TASK_SLOTS))) begin
                        r_res_qdone <= 1'b1;
                    end else begin
                        r_res_qdone <= r_done[r_qidx[rrtp_pkg::SLOT_W-1:0]];
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd_ctl.scan && !o_sts.hit) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd_ctl.load) begin
            r_o_status   <= r_res_status;
            r_o_assigned <= r_res_assigned;
            r_o_main     <= r_main;
            r_o_task     <= r_main ? '0 : r_cur;
            r_o_total    <= r_count;
            r_o_qdone    <= r_res_qdone;
        end
    end

    assign o_status          = r_o_status;
    assign o_assigned_slot   = r_o_assigned;
    assign o_running_is_main = r_o_main;
    assign o_running_task    = r_o_task;
    assign o_task_total      = r_o_total;
    assign o_queried_done    = r_o_qdone;

endmodule

FILE: rtl/round_robin_task_picker_core.sv
// channel  | handshake          | payload
// ---------+--------------------+----------------------------------------------
// command  | i_valid / o_ready  | i_cmd, i_process_active, i_task_index
// result   | o_valid / i_ready  | o_status, o_assigned_slot, o_running_is_main,
//          |                    | o_running_task, o_task_total, o_queried_done
// config   | i_cfg_we           | i_cfg_wdata (preemption enable)
//
// One transaction at a time: o_valid rises after EXEC, a SCAN rotation if
// needed over the n tasks and main, where n is the task count (8 at most),
// and OUT; the next command is accepted only once the FSM is back in IDLE.
// Synchronous active-low reset puts the main slot in charge with no tasks.
// A stalled result holds in the output register; the next command is
// accepted while it waits.
module round_robin_task_picker_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rrtp_pkg::CMD_W-1:0]   i_cmd,
    input  logic                         i_process_active,
    input  logic [rrtp_pkg::QIDX_W-1:0]  i_task_index,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_status,
    output logic [rrtp_pkg::SLOT_W-1:0]  o_assigned_slot,
    output logic                         o_running_is_main,
    output logic [rrtp_pkg::SLOT_W-1:0]  o_running_task,
    output logic [rrtp_pkg::CNT_W-1:0]   o_task_total,
    output logic                         o_queried_done,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata
);

    rrtp_pkg::t_dp_cmd cmd_ctl;
    rrtp_pkg::t_dp_sts sts;

    rrtp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd_ctl)
    );

    rrtp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_ctl         (cmd_ctl),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_cmd             (i_cmd),
        .i_process_active  (i_process_active),
        .i_task_index      (i_task_index),
        .o_status          (o_status),
        .o_assigned_slot   (o_assigned_slot),
        .o_running_is_main (o_running_is_main),
        .o_running_task    (o_running_task),
        .o_task_total      (o_task_total),
        .o_queried_done    (o_queried_done)
    );

endmodule

FILE: tb/tb_round_robin_task_picker_core.sv
module tb_round_robin_task_picker_core;

    localparam logic [rrtp_pkg::CMD_W-1:0] CMD_TOP = '1;
    localparam int QIDX_MAX       = 2**rrtp_pkg::QIDX_W - 1;
    localparam int RAND_PER_PHASE = 542;
    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 30;

    typedef struct packed {
        logic                        status;
        logic [rrtp_pkg::SLOT_W-1:0] new_slot;
        logic                        on_main;
        logic [rrtp_pkg::SLOT_W-1:0] run_slot;
        logic [rrtp_pkg::CNT_W-1:0]  total;
        logic                        queried_done;
    } t_picker_result;

    class picker_scoreboard;
        bit                            preempt;
        logic [rrtp_pkg::CNT_W-1:0]    n_tasks;
        bit                            main_on;
        logic [rrtp_pkg::SLOT_W-1:0]   cur;
        bit [rrtp_pkg::TASK_SLOTS-1:0] done_bits;
        t_picker_result                pending[$];
        int                            errors;

        function new();
            preempt   = 1'b0;
            n_tasks   = '0;
            main_on   = 1'b1;
            cur       = '0;
            done_bits = '0;
            errors    = 0;
        endfunction

        // rotate to the next slot that is not done; main closes the ring
        function void advance();
            int n;
            int span;
            int from;
            int k;
            n = int'(n_tasks);
            if (n == 0) return;
            span = n + 1;
            from = main_on ? n : int'(cur);
            for (int i = 1; i <= span; i++) begin
                k = (from + i) % span;
                if (k == n) begin
                    main_on = 1'b1;
                    cur     = '0;
                    return;
                end
                if (!done_bits[k]) begin
                    main_on = 1'b0;
                    cur     = k[rrtp_pkg::SLOT_W-1:0];
                    return;
                end
            end
        endfunction

        function void note_cmd(logic [rrtp_pkg::CMD_W-1:0] c, logic pact,
                               logic [rrtp_pkg::QIDX_W-1:0] q);
            t_picker_result r;
            r = '0;
            case (c)
                rrtp_pkg::CMD_CREATE: begin
                    if (n_tasks >= rrtp_pkg::TASK_SLOTS) begin
                        r.status = 1'b1;
                    end else begin
                        r.new_slot = n_tasks[rrtp_pkg::SLOT_W-1:0];
                        done_bits[n_tasks[rrtp_pkg::SLOT_W-1:0]] = 1'b0;
                        n_tasks++;
                    end
                end
                rrtp_pkg::CMD_YIELD: advance();
                rrtp_pkg::CMD_TICK: begin
                    if (preempt && !pact && n_tasks != 0) advance();
                end
                rrtp_pkg::CMD_FINISH: begin
                    if (!main_on) begin
                        done_bits[cur] = 1'b1;
                        advance();
                    end
                end
                rrtp_pkg::CMD_QUERY: begin
                    if (q >= n_tasks) r.queried_done = 1'b1;
                    else r.queried_done = done_bits[q[rrtp_pkg::SLOT_W-1:0]];
                end
                default: ;
            endcase
            r.on_main  = main_on;
            r.run_slot = main_on ? '0 : cur;
            r.total    = n_tasks;
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task cmp_field(string name, logic [3:0] got, logic [3:0] want);
            if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(t_picker_result got);
            t_picker_result want;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending: %p", got));
                return;
            end
            want = pending.pop_front();
            cmp_field("status", 4'(got.status), 4'(want.status));
            cmp_field("assigned_slot", 4'(got.new_slot), 4'(want.new_slot));
            cmp_field("running_is_main", 4'(got.on_main), 4'(want.on_main));
            cmp_field("running_task", 4'(got.run_slot), 4'(want.run_slot));
            cmp_field("task_total", got.total, want.total);
            cmp_field("queried_done", 4'(got.queried_done), 4'(want.queried_done));
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [rrtp_pkg::CMD_W-1:0]  i_cmd = '0;
    logic                        i_process_active = 1'b0;
    logic [rrtp_pkg::QIDX_W-1:0] i_task_index = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic                        o_status;
    logic [rrtp_pkg::SLOT_W-1:0] o_assigned_slot;
    logic                        o_running_is_main;
    logic [rrtp_pkg::SLOT_W-1:0] o_running_task;
    logic [rrtp_pkg::CNT_W-1:0]  o_task_total;
    logic                        o_queried_done;
    logic                        i_cfg_we = 1'b0;
    logic                        i_cfg_wdata = 1'b0;

    picker_scoreboard sb;
    int               send_idle = 0;
    int               recv_idle = 0;
    int               quiet_cycles = 0;
    bit               moved;
    t_picker_result   seen;

    round_robin_task_picker_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_process_active  (i_process_active),
        .i_task_index      (i_task_index),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_assigned_slot   (o_assigned_slot),
        .o_running_is_main (o_running_is_main),
        .o_running_task    (o_running_task),
        .o_task_total      (o_task_total),
        .o_queried_done    (o_queried_done),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_valid && o_ready) begin
                sb.note_cmd(i_cmd, i_process_active, i_task_index);
                moved = 1'b1;
            end
            if (o_valid && i_ready) begin
                seen = '{o_status, o_assigned_slot, o_running_is_main,
                         o_running_task, o_task_total, o_queried_done};
                sb.check_result(seen);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // enter and leave at a falling edge
    task automatic send_cmd(input logic [rrtp_pkg::CMD_W-1:0] c, input logic pact,
                            input logic [rrtp_pkg::QIDX_W-1:0] q);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_cmd            <= c;
        i_process_active <= pact;
        i_task_index     <= q;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int                         r;
        logic [rrtp_pkg::CMD_W-1:0] c;
        r = $urandom_range(99);
        if (r < 4) c = rrtp_pkg::CMD_CREATE;
        else if (r < 34) c = rrtp_pkg::CMD_YIELD;
        else if (r < 62) c = rrtp_pkg::CMD_TICK;
        else if (r < 65) c = rrtp_pkg::CMD_FINISH;
        else if (r < 92) c = rrtp_pkg::CMD_QUERY;
        else c = rrtp_pkg::CMD_W'($urandom_range(CMD_TOP, rrtp_pkg::CMD_QUERY + 1));
        send_cmd(c, 1'($urandom_range(1)), rrtp_pkg::QIDX_W'($urandom_range(QIDX_MAX)));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_preempt(input bit v);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.preempt = v;
    endtask

    initial begin
        sb = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_preempt(1'b0);
        send_cmd(rrtp_pkg::CMD_YIELD, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_TICK, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_FINISH, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_QUERY, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_QUERY, 1'b1, rrtp_pkg::QIDX_W'(QIDX_MAX));
        for (int c = rrtp_pkg::CMD_QUERY + 1; c <= CMD_TOP; c++) begin
            send_cmd(rrtp_pkg::CMD_W'(c), 1'b1, rrtp_pkg::QIDX_W'(QIDX_MAX));
        end
        send_cmd(rrtp_pkg::CMD_CREATE, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_CREATE, 1'b1, '0);
        send_cmd(rrtp_pkg::CMD_TICK, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_YIELD, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_QUERY, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_FINISH, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_QUERY, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_YIELD, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_YIELD, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_FINISH, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_YIELD, 1'b0, '0);

        write_preempt(1'b1);
        send_cmd(rrtp_pkg::CMD_TICK, 1'b1, '0);
        send_cmd(rrtp_pkg::CMD_CREATE, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_TICK, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_TICK, 1'b0, '0);
        send_cmd(rrtp_pkg::CMD_QUERY, 1'b0, rrtp_pkg::QIDX_W'(2));
        send_cmd(rrtp_pkg::CMD_QUERY, 1'b0, rrtp_pkg::QIDX_W'(rrtp_pkg::TASK_SLOTS));

        send_idle = 11;
        recv_idle = 72;
        repeat (RAND_PER_PHASE) send_random();

        write_preempt(1'b0);
        send_idle = 72;
        recv_idle = 11;
        repeat (RAND_PER_PHASE) send_random();

        write_preempt(1'b1);
        send_idle = 0;
        recv_idle = 0;
        repeat (RAND_PER_PHASE) send_random();

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
